// ===== rtl/core/q2e_pkg.sv =====
// Shared widths, latencies and constant tables for the quaternion to Euler angle block.
// Used by q2e_atan2, q2e_pitch_arg and quaternion_to_euler; depends on nothing.
`default_nettype none

package q2e_pkg;

  // Input component width and the widths of the products and sums built from it.
  localparam int QuatWidth = 16;
  localparam int ProdWidth = 2 * QuatWidth;
  localparam int SumWidth  = ProdWidth + 2;
  localparam int MagWidth  = SumWidth - 1;

  // Arctangent datapath: normalized vector, CORDIC registers and angle widths (Q30 radians).
  localparam int NormWidth   = 30;
  localparam int CordWidth   = 33;
  localparam int ZWidth      = 33;
  localparam int AngWidth    = 34;
  localparam int LeadWidth   = 6;
  localparam int CordicSteps = 30;

  // Arcsine argument: quotient, square root and their step counts.
  localparam int DivSteps     = 30;
  localparam int QWidth       = 31;
  localparam int SqrtSteps    = 31;
  localparam int RadWidth     = 2 * SqrtSteps;
  localparam int SqrtRemWidth = 35;

  // Pipeline depths in register stages.
  localparam int AtanLat  = 3 + CordicSteps + 1;
  localparam int PitchLat = 1 + DivSteps + 1 + 1 + SqrtSteps;
  localparam int PipeLat  = 3 + PitchLat + AtanLat + 2;

  // Output conversion.
  localparam int AngOutWidth = 16;
  localparam int MagOutWidth = 32;
  localparam int ScaleWidth  = 29;
  localparam int ProdOutWidth = MagOutWidth + ScaleWidth;

  localparam logic [AngWidth-1:0]   PiQ30       = 34'd3373259426;
  localparam logic [AngWidth-1:0]   HalfPiQ30   = 34'd1686629713;
  localparam logic [ScaleWidth-1:0] Deg100Scale = 29'd375493621;

  // atan(2^-i) in Q30 radians, one entry per CORDIC stage.
  localparam logic [ZWidth-1:0] AtanTable [CordicSteps] = '{
    33'h03243F6A8, 33'h01DAC6705, 33'h00FADBAFC, 33'h007F56EA6, 33'h003FEAB76,
    33'h001FFD55B, 33'h000FFFAAA, 33'h0007FFF55, 33'h0003FFFEA, 33'h0001FFFFD,
    33'h0000FFFFF, 33'h00007FFFF, 33'h00003FFFF, 33'h00001FFFF, 33'h00000FFFF,
    33'h000007FFF, 33'h000003FFF, 33'h000001FFF, 33'h000000FFF, 33'h0000007FF,
    33'h0000003FF, 33'h0000001FF, 33'h0000000FF, 33'h00000007F, 33'h00000003F,
    33'h00000001F, 33'h00000000F, 33'h000000008, 33'h000000004, 33'h000000002
  };

  // Side information of the arcsine argument, handed from q2e_pitch_arg to the top level.
  typedef struct packed {
    logic neg;
    logic clipped;
  } pitch_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/quaternion_to_euler.sv =====
// Top level: quaternion (Q14) in, Z-Y-X Euler angles out, fully pipelined.
// Depends on q2e_pkg, q2e_pitch_arg and q2e_atan2.
//
//   channel   direction  handshake             payload
//   s_axis    in         tvalid/tready         tdata: real, i, j, k (16 b each)
//   m_axis    out        tvalid/tready         tdata: yaw, pitch, roll; tuser: pitch_clipped
//   cfg       in         cfg_we_i              cfg_wdata_i: degrees_mode
//
// One quaternion is taken per cycle while no finished result waits on m_axis_tready; the
// pipeline depth (103 register stages) is set by the pitch path (30 divide stages, 31
// square-root stages, 30 CORDIC stages).
// Reset clears only the stage valid bits and the unit select; no clearing pass is needed.
// The whole pipeline holds while a result waits on m_axis_tready, so s_axis_tready
// falls in that cycle and nothing is dropped or repeated.
`default_nettype none

module quaternion_to_euler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // quat_real, quat_i, quat_j, quat_k
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // yaw_angle, pitch_angle, roll_angle
  output logic [0:0]       m_axis_tuser    // pitch_clipped
);

  localparam int QW = q2e_pkg::QuatWidth;
  localparam int PW = q2e_pkg::ProdWidth;
  localparam int SW = q2e_pkg::SumWidth;
  localparam int AW = q2e_pkg::AngWidth;
  localparam int OW = q2e_pkg::AngOutWidth;

  localparam logic signed [OW-1:0] RadPi     = 16'sd25736;
  localparam logic signed [OW-1:0] RadHalfPi = 16'sd12868;
  localparam logic signed [OW-1:0] DegHalfPi = 16'sd9000;

  function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] p);
    return {{(SW-PW){p[PW-1]}}, p};
  endfunction

  // Unit select register.
  logic deg_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      deg_mode_q <= cfg_wdata_i;
    end
  end

  // Global advance: every stage moves unless a finished result is still waiting.
  logic                     adv;
  logic [q2e_pkg::PipeLat-1:0] vld_q;

  assign adv           = !vld_q[q2e_pkg::PipeLat-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[q2e_pkg::PipeLat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[q2e_pkg::PipeLat-2:0], s_axis_tvalid};
    end
  end

  // Stage 0: input registers.
  logic signed [QW-1:0] qr_q, qi_q, qj_q, qk_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qr_q <= s_axis_tdata[QW-1:0];
      qi_q <= s_axis_tdata[2*QW-1:QW];
      qj_q <= s_axis_tdata[3*QW-1:2*QW];
      qk_q <= s_axis_tdata[4*QW-1:3*QW];
    end
  end

  // Stage 1: all pairwise products.
  logic signed [PW-1:0] sr_q, si_q, sj_q, sk_q;
  logic signed [PW-1:0] ij_q, kr_q, jk_q, ir_q, jr_q, ik_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sr_q <= qr_q * qr_q;
      si_q <= qi_q * qi_q;
      sj_q <= qj_q * qj_q;
      sk_q <= qk_q * qk_q;
      ij_q <= qi_q * qj_q;
      kr_q <= qk_q * qr_q;
      jk_q <= qj_q * qk_q;
      ir_q <= qi_q * qr_q;
      jr_q <= qj_q * qr_q;
      ik_q <= qi_q * qk_q;
    end
  end

  // Stage 2: arctangent operands, arcsine numerator and squared norm.
  logic signed [SW-1:0]               yaw_y_q, yaw_x_q, roll_y_q, roll_x_q, num_q;
  logic        [q2e_pkg::MagWidth-1:0] den_q;
  logic signed [SW-1:0]               den_full;

  assign den_full = ext(si_q) + ext(sj_q) + ext(sk_q) + ext(sr_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yaw_y_q  <= (ext(ij_q) + ext(kr_q)) <<< 1;
      yaw_x_q  <= ext(si_q) - ext(sj_q) - ext(sk_q) + ext(sr_q);
      roll_y_q <= (ext(jk_q) + ext(ir_q)) <<< 1;
      roll_x_q <= ext(sk_q) + ext(sr_q) - ext(si_q) - ext(sj_q);
      num_q    <= (ext(jr_q) - ext(ik_q)) <<< 1;
      den_q    <= den_full[q2e_pkg::MagWidth-1:0];
    end
  end

  // Yaw and roll arctangents run early and wait in delay lines for the pitch path.
  logic signed [AW-1:0] yaw_z, roll_z;

  q2e_atan2 u_yaw_atan (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (yaw_y_q),
    .x_i   (yaw_x_q),
    .z_o   (yaw_z)
  );

  q2e_atan2 u_roll_atan (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (roll_y_q),
    .x_i   (roll_x_q),
    .z_o   (roll_z)
  );

  logic signed [AW-1:0] yaw_dly_q  [q2e_pkg::PitchLat];
  logic signed [AW-1:0] roll_dly_q [q2e_pkg::PitchLat];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yaw_dly_q[0]  <= yaw_z;
      roll_dly_q[0] <= roll_z;
      for (int k = 1; k < q2e_pkg::PitchLat; k++) begin
        yaw_dly_q[k]  <= yaw_dly_q[k-1];
        roll_dly_q[k] <= roll_dly_q[k-1];
      end
    end
  end

  // Pitch: arcsine argument, then atan2(q, sqrt(1 - q^2)) with the numerator's sign.
  logic [q2e_pkg::QWidth-1:0] pq, proot;
  q2e_pkg::pitch_flags_t      pflags;

  q2e_pitch_arg u_pitch_arg (
    .clk_i   (clk_i),
    .en_i    (adv),
    .num_i   (num_q),
    .den_i   (den_q),
    .q_o     (pq),
    .root_o  (proot),
    .flags_o (pflags)
  );

  logic signed [AW-1:0] pitch_y, pitch_x, pitch_z;

  assign pitch_y = pflags.neg ? -{{(AW-q2e_pkg::QWidth){1'b0}}, pq}
                              :  {{(AW-q2e_pkg::QWidth){1'b0}}, pq};
  assign pitch_x = {{(AW-q2e_pkg::QWidth){1'b0}}, proot};

  q2e_atan2 u_pitch_atan (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (pitch_y),
    .x_i   (pitch_x),
    .z_o   (pitch_z)
  );

  logic clip_dly_q [q2e_pkg::AtanLat];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      clip_dly_q[0] <= pflags.clipped;
      for (int k = 1; k < q2e_pkg::AtanLat; k++) begin
        clip_dly_q[k] <= clip_dly_q[k-1];
      end
    end
  end

  // Output conversion, two stages per lane: scale, then round half away from zero.
  logic signed [AW-1:0] lane_z [3];

  assign lane_z[0] = yaw_dly_q[q2e_pkg::PitchLat-1];
  assign lane_z[1] = pitch_z;
  assign lane_z[2] = roll_dly_q[q2e_pkg::PitchLat-1];

  logic        [q2e_pkg::MagOutWidth-1:0]  mag_q  [3];
  logic        [q2e_pkg::ProdOutWidth-1:0] prod_q [3];
  logic                                    neg_q  [3];
  logic signed [OW-1:0]                    ang_q  [3];
  logic                                    clip_a_q, clip_q;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [AW-1:0]                     zabs;
    logic [q2e_pkg::MagOutWidth-1:0]   m;
    logic [q2e_pkg::MagOutWidth:0]     rad_sum;
    logic [q2e_pkg::ProdOutWidth:0]    deg_sum;
    logic [OW-1:0]                     mo;

    assign zabs    = lane_z[l][AW-1] ? -lane_z[l] : lane_z[l];
    assign m       = zabs[q2e_pkg::MagOutWidth-1:0];
    assign rad_sum = {1'b0, mag_q[l]} + (33'd1 << 16);
    assign deg_sum = {1'b0, prod_q[l]} + (62'd1 << 45);
    assign mo      = deg_mode_q ? deg_sum[46 +: OW] : rad_sum[17 +: OW];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        mag_q[l]  <= m;
        prod_q[l] <= m * q2e_pkg::Deg100Scale;
        neg_q[l]  <= lane_z[l][AW-1];
        ang_q[l]  <= neg_q[l] ? -mo : mo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      clip_a_q <= clip_dly_q[q2e_pkg::AtanLat-1];
      clip_q   <= clip_a_q;
    end
  end

  assign m_axis_tdata = {ang_q[2], ang_q[1], ang_q[0]};
  assign m_axis_tuser = clip_q;

  // A saturated arcsine always ends at exactly plus or minus a quarter turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && clip_q |->
      ang_q[1] == RadHalfPi || ang_q[1] == -RadHalfPi ||
      ang_q[1] == DegHalfPi || ang_q[1] == -DegHalfPi)
    else $error("clipped pitch is not a quarter turn");

  // Pitch never leaves the closed quarter-turn range; the check uses the radian bound in either unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ang_q[1] <= RadHalfPi && ang_q[1] >= -RadHalfPi)
    else $error("pitch out of range");

  // Yaw and roll stay within half a turn; the check uses the radian bound in either unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ang_q[0] <= RadPi && ang_q[0] >= -RadPi &&
                      ang_q[2] <= RadPi && ang_q[2] >= -RadPi)
    else $error("yaw or roll out of range");

  // A new result only shows up after its item reached the first conversion stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[q2e_pkg::PipeLat-2]))
    else $error("result valid without a preceding stage");

endmodule

`default_nettype wire

// ===== rtl/core/q2e_atan2.sv =====
// Pipelined four-quadrant arctangent: magnitude, leading-one search, normalize, CORDIC, fix-up.
// Depends on q2e_pkg for widths, the angle table and the stage count.
`default_nettype none

module q2e_atan2 (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic signed [q2e_pkg::AngWidth-1:0]  y_i,
  input  wire logic signed [q2e_pkg::AngWidth-1:0]  x_i,
  output logic signed      [q2e_pkg::AngWidth-1:0]  z_o
);

  localparam logic [q2e_pkg::LeadWidth-1:0] NormTop =
    q2e_pkg::LeadWidth'(q2e_pkg::NormWidth - 1);

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic y_zero;
    logic x_zero;
  } quad_t;

  function automatic logic [q2e_pkg::LeadWidth-1:0] lead_one(
    input logic [q2e_pkg::MagWidth-1:0] v
  );
    logic [q2e_pkg::LeadWidth-1:0] pos;
    pos = '0;
    for (int b = 0; b < q2e_pkg::MagWidth; b++) begin
      if (v[b]) pos = q2e_pkg::LeadWidth'(b);
    end
    return pos;
  endfunction

  // Stage 1: magnitudes and quadrant flags.
  logic [q2e_pkg::AngWidth-1:0] ay_full, ax_full;
  logic [q2e_pkg::MagWidth-1:0] ay1_q, ax1_q;
  quad_t                        fl1_q;

  assign ay_full = y_i[q2e_pkg::AngWidth-1] ? -y_i : y_i;
  assign ax_full = x_i[q2e_pkg::AngWidth-1] ? -x_i : x_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ay1_q        <= ay_full[q2e_pkg::MagWidth-1:0];
      ax1_q        <= ax_full[q2e_pkg::MagWidth-1:0];
      fl1_q.x_neg  <= x_i[q2e_pkg::AngWidth-1];
      fl1_q.y_neg  <= y_i[q2e_pkg::AngWidth-1];
      fl1_q.y_zero <= (y_i == '0);
      fl1_q.x_zero <= (x_i == '0);
    end
  end

  // Stage 2: position of the leading one of the larger magnitude.
  logic [q2e_pkg::MagWidth-1:0]  ay2_q, ax2_q;
  logic [q2e_pkg::LeadWidth-1:0] lead_q;
  quad_t                         fl2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ay2_q  <= ay1_q;
      ax2_q  <= ax1_q;
      lead_q <= lead_one(ay1_q | ax1_q);
      fl2_q  <= fl1_q;
    end
  end

  // Stage 3: shift both magnitudes so that the larger one has its top bit just below 2^30.
  logic [q2e_pkg::LeadWidth-1:0] shamt;
  logic [q2e_pkg::MagWidth-1:0]  ax_n, ay_n;

  always_comb begin
    if (lead_q > NormTop) begin
      shamt = lead_q - NormTop;
      ax_n  = ax2_q >> shamt;
      ay_n  = ay2_q >> shamt;
    end else begin
      shamt = NormTop - lead_q;
      ax_n  = ax2_q << shamt;
      ay_n  = ay2_q << shamt;
    end
  end

  logic signed [q2e_pkg::CordWidth-1:0] cx_q [q2e_pkg::CordicSteps+1];
  logic signed [q2e_pkg::CordWidth-1:0] cy_q [q2e_pkg::CordicSteps+1];
  logic signed [q2e_pkg::ZWidth-1:0]    z_q  [q2e_pkg::CordicSteps+1];
  quad_t                                fl_q [q2e_pkg::CordicSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= {{(q2e_pkg::CordWidth-q2e_pkg::NormWidth){1'b0}},
                  ax_n[q2e_pkg::NormWidth-1:0]};
      cy_q[0] <= {{(q2e_pkg::CordWidth-q2e_pkg::NormWidth){1'b0}},
                  ay_n[q2e_pkg::NormWidth-1:0]};
      z_q[0]  <= '0;
      fl_q[0] <= fl2_q;
    end
  end

  // CORDIC vectoring stages, one rotation per register stage.
  for (genvar i = 0; i < q2e_pkg::CordicSteps; i++) begin : g_step
    logic signed [q2e_pkg::CordWidth-1:0] dx, dy;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cy_q[i][q2e_pkg::CordWidth-1]) begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          z_q[i+1]  <= z_q[i] + $signed(q2e_pkg::AtanTable[i]);
        end else begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          z_q[i+1]  <= z_q[i] - $signed(q2e_pkg::AtanTable[i]);
        end
        fl_q[i+1] <= fl_q[i];
      end
    end
  end

  // Fix-up: axis cases, then reflect into the right quadrant.
  logic signed [q2e_pkg::AngWidth-1:0] z_fix;
  quad_t                               fl_end;

  assign fl_end = fl_q[q2e_pkg::CordicSteps];

  always_comb begin
    if (fl_end.y_zero) begin
      z_fix = '0;
    end else if (fl_end.x_zero) begin
      z_fix = $signed(q2e_pkg::HalfPiQ30);
    end else begin
      z_fix = {{(q2e_pkg::AngWidth-q2e_pkg::ZWidth){z_q[q2e_pkg::CordicSteps][q2e_pkg::ZWidth-1]}},
               z_q[q2e_pkg::CordicSteps]};
    end
    if (fl_end.x_neg) z_fix = $signed(q2e_pkg::PiQ30) - z_fix;
    if (fl_end.y_neg) z_fix = -z_fix;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_o <= z_fix;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/q2e_pitch_arg.sv =====
// Pitch argument pipeline: saturating restoring divide of |num| by the squared norm,
// then the cosine side as floor sqrt(2^60 - q^2). Depends on q2e_pkg.
`default_nettype none

module q2e_pitch_arg (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [q2e_pkg::SumWidth-1:0] num_i,
  input  wire logic        [q2e_pkg::MagWidth-1:0] den_i,
  output logic             [q2e_pkg::QWidth-1:0]   q_o,
  output logic             [q2e_pkg::QWidth-1:0]   root_o,
  output q2e_pkg::pitch_flags_t                    flags_o
);

  typedef struct packed {
    logic neg;
    logic one;
    logic zero;
  } div_flags_t;

  localparam logic [q2e_pkg::QWidth-1:0]   QOne   = q2e_pkg::QWidth'(1) << q2e_pkg::DivSteps;
  localparam logic [q2e_pkg::RadWidth-1:0] OneSq  = q2e_pkg::RadWidth'(1) << (2*q2e_pkg::DivSteps);

  // Prep stage: magnitude, zero norm and saturation test.
  logic [q2e_pkg::SumWidth-1:0] n_full;
  logic [q2e_pkg::MagWidth-1:0] n_mag;

  assign n_full = num_i[q2e_pkg::SumWidth-1] ? -num_i : num_i;
  assign n_mag  = n_full[q2e_pkg::MagWidth-1:0];

  logic [q2e_pkg::MagWidth-1:0] rem_q [q2e_pkg::DivSteps+1];
  logic [q2e_pkg::MagWidth-1:0] d_q   [q2e_pkg::DivSteps+1];
  logic [q2e_pkg::DivSteps-1:0] qd_q  [q2e_pkg::DivSteps+1];
  div_flags_t                   df_q  [q2e_pkg::DivSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]     <= n_mag;
      d_q[0]       <= den_i;
      qd_q[0]      <= '0;
      df_q[0].neg  <= num_i[q2e_pkg::SumWidth-1];
      df_q[0].zero <= (den_i == '0);
      df_q[0].one  <= (den_i != '0) && (n_mag >= den_i);
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar i = 0; i < q2e_pkg::DivSteps; i++) begin : g_div
    logic [q2e_pkg::MagWidth:0] trial, diff;
    logic                       ge;
    assign trial = {rem_q[i], 1'b0};
    assign diff  = trial - {1'b0, d_q[i]};
    assign ge    = (trial >= {1'b0, d_q[i]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? diff[q2e_pkg::MagWidth-1:0] : trial[q2e_pkg::MagWidth-1:0];
        d_q[i+1]   <= d_q[i];
        qd_q[i+1]  <= {qd_q[i][q2e_pkg::DivSteps-2:0], ge};
        df_q[i+1]  <= df_q[i];
      end
    end
  end

  // Quotient with saturation applied, and its square.
  div_flags_t                   df_end;
  logic [q2e_pkg::QWidth-1:0]   q_fin;

  assign df_end = df_q[q2e_pkg::DivSteps];

  always_comb begin
    if (df_end.one) begin
      q_fin = QOne;
    end else if (df_end.zero) begin
      q_fin = '0;
    end else begin
      q_fin = {1'b0, qd_q[q2e_pkg::DivSteps]};
    end
  end

  logic [q2e_pkg::QWidth-1:0]   qm_q;
  logic [q2e_pkg::RadWidth-1:0] sq_q;
  div_flags_t                   fm_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qm_q <= q_fin;
      sq_q <= q_fin * q_fin;
      fm_q <= df_end;
    end
  end

  // Radicand stage, then a digit-by-digit floor square root, one root bit per stage.
  logic [q2e_pkg::RadWidth-1:0]     vv_q   [q2e_pkg::SqrtSteps+1];
  logic [q2e_pkg::QWidth-1:0]       root_q [q2e_pkg::SqrtSteps+1];
  logic [q2e_pkg::SqrtRemWidth-1:0] srem_q [q2e_pkg::SqrtSteps+1];
  logic [q2e_pkg::QWidth-1:0]       qs_q   [q2e_pkg::SqrtSteps+1];
  div_flags_t                       fs_q   [q2e_pkg::SqrtSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vv_q[0]   <= OneSq - sq_q;
      root_q[0] <= '0;
      srem_q[0] <= '0;
      qs_q[0]   <= qm_q;
      fs_q[0]   <= fm_q;
    end
  end

  for (genvar s = 0; s < q2e_pkg::SqrtSteps; s++) begin : g_sqrt
    logic [q2e_pkg::SqrtRemWidth-1:0] cur, trial;
    logic                             ge;
    assign cur   = {srem_q[s][q2e_pkg::SqrtRemWidth-3:0],
                    vv_q[s][q2e_pkg::RadWidth-1-2*s -: 2]};
    assign trial = {{(q2e_pkg::SqrtRemWidth-q2e_pkg::QWidth-2){1'b0}}, root_q[s], 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srem_q[s+1] <= ge ? (cur - trial) : cur;
        root_q[s+1] <= {root_q[s][q2e_pkg::QWidth-2:0], ge};
        vv_q[s+1]   <= vv_q[s];
        qs_q[s+1]   <= qs_q[s];
        fs_q[s+1]   <= fs_q[s];
      end
    end
  end

  assign q_o             = qs_q[q2e_pkg::SqrtSteps];
  assign root_o          = root_q[q2e_pkg::SqrtSteps];
  assign flags_o.neg     = fs_q[q2e_pkg::SqrtSteps].neg;
  assign flags_o.clipped = fs_q[q2e_pkg::SqrtSteps].one;

endmodule

`default_nettype wire
